// ----- rtl/plt_pkg.sv -----
`default_nettype none

package plt_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned MaxResults   = 16;

  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned FireW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_REG   = 2'd1,
    OP_UNREG = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    EV_FIRED    = 3'd0,
    EV_NONE     = 3'd1,
    EV_ADDED    = 3'd2,
    EV_UPDATED  = 3'd3,
    EV_FULL     = 3'd4,
    EV_REMOVED  = 3'd5,
    EV_NOTFOUND = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  listener_id;
    logic [31:0] period_us;
  } cmd_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] fired_id;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] period;
    logic [31:0] remaining;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/periodic_listener_timer_table_core.sv -----
// Tick: one entry read and written a cycle.
// Register: key scan; one result in the last busy cycle.
// Unregister: key scan, then each entry behind the match is moved up one place.
// The next command is taken at the first edge after busy falls.
// Reset clears entry count and sets the interval to 1000; entries are not cleared.
// Results appear one cycle each on res_valid_o; the receiver cannot stall.
`default_nettype none

module periodic_listener_timer_table_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output      logic          busy,
  input  wire plt_pkg::cmd_t cmd_i,
  input  wire logic          cfg_we_i,
  input  wire logic [31:0]   cfg_wdata_i,
  output      logic          res_valid_o,
  output      plt_pkg::res_t res_o
);
  import plt_pkg::*;

  state_e state_q, state_d;

  logic [1:0]      op_q;
  logic [7:0]      id_q;
  logic [31:0]     period_q;
  logic [31:0]     interval_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_pos_q;
  logic            pend_vld_q, pend_vld_d;
  logic [7:0]      pend_id_q, pend_id_d;
  logic [FireW-1:0] nfired_q, nfired_d;

  entry_t          mem [TableEntries];
  entry_t          rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  entry_t          mem_wd;

  logic issue_ok;
  logic match_now;
  logic fire;
  logic accept;

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);
  assign issue_ok  = (rd_idx_q < count_q);
  assign match_now = rd_vld_q && (rdata_q.key == id_q);
  assign fire      = (rdata_q.remaining <= interval_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.op)
            OP_TICK:  state_d = ST_TICK;
            OP_REG:   state_d = ST_SCAN;
            OP_UNREG: state_d = ST_SCAN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        if (!issue_ok && !rd_vld_q) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (match_now) begin
          state_d = (op_q == OP_UNREG) ? ST_SHIFT : ST_IDLE;
        end else if (!issue_ok && !rd_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (!issue_ok && !rd_vld_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    pend_vld_d  = pend_vld_q;
    pend_id_d   = pend_id_q;
    nfired_d    = nfired_q;
    mem_we      = 1'b0;
    mem_wa      = rd_pos_q;
    mem_wd      = rdata_q;
    res_valid_o = 1'b0;
    res_o       = '{event_res: EV_NONE, fired_id: 8'd0, last: 1'b1};

    case (state_q)
      ST_IDLE: begin
        rd_idx_d   = '0;
        pend_vld_d = 1'b0;
        nfired_d   = '0;
      end
      ST_TICK: begin
        if (issue_ok) begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (rd_vld_q) begin
          mem_we           = 1'b1;
          mem_wd.remaining = fire ? rdata_q.period : (rdata_q.remaining - interval_q);
          if (fire && (nfired_q < FireW'(MaxResults))) begin
            if (pend_vld_q) begin
              res_valid_o = 1'b1;
              res_o       = '{event_res: EV_FIRED, fired_id: pend_id_q, last: 1'b0};
            end
            pend_vld_d = 1'b1;
            pend_id_d  = rdata_q.key;
            nfired_d   = nfired_q + FireW'(1);
          end
        end else if (!issue_ok) begin
          res_valid_o = 1'b1;
          if (pend_vld_q) begin
            res_o = '{event_res: EV_FIRED, fired_id: pend_id_q, last: 1'b1};
          end
        end
      end
      ST_SCAN: begin
        if (match_now) begin
          if (op_q == OP_UNREG) begin
            rd_idx_d = CntW'(rd_pos_q) + CntW'(1);
          end else begin
            mem_we      = 1'b1;
            mem_wd      = '{key: id_q, period: period_q, remaining: period_q};
            res_valid_o = 1'b1;
            res_o       = '{event_res: EV_UPDATED, fired_id: id_q, last: 1'b1};
          end
        end else begin
          if (issue_ok) begin
            rd_vld_d = 1'b1;
            rd_idx_d = rd_idx_q + CntW'(1);
          end else if (!rd_vld_q) begin
            res_valid_o = 1'b1;
            if (op_q == OP_UNREG) begin
              res_o = '{event_res: EV_NOTFOUND, fired_id: id_q, last: 1'b1};
            end else if (count_q == CntW'(TableEntries)) begin
              res_o = '{event_res: EV_FULL, fired_id: id_q, last: 1'b1};
            end else begin
              mem_we  = 1'b1;
              mem_wa  = count_q[IdxW-1:0];
              mem_wd  = '{key: id_q, period: period_q, remaining: period_q};
              count_d = count_q + CntW'(1);
              res_o   = '{event_res: EV_ADDED, fired_id: id_q, last: 1'b1};
            end
          end
        end
      end
      ST_SHIFT: begin
        if (issue_ok) begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (rd_vld_q) begin
          mem_we = 1'b1;
          mem_wa = rd_pos_q - IdxW'(1);
        end else if (!issue_ok) begin
          count_d     = count_q - CntW'(1);
          res_valid_o = 1'b1;
          res_o       = '{event_res: EV_REMOVED, fired_id: id_q, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rd_idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q  <= rd_idx_q[IdxW-1:0];
    pend_id_q <= pend_id_d;
    if (accept) begin
      op_q     <= cmd_i.op;
      id_q     <= cmd_i.listener_id;
      period_q <= cmd_i.period_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      nfired_q   <= '0;
      interval_q <= 32'd1000;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      rd_vld_q   <= rd_vld_d;
      pend_vld_q <= pend_vld_d;
      nfired_q   <= nfired_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/plt_checker.sv -----
`default_nettype none

module plt_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire plt_pkg::cmd_t cmd_i,
  input wire logic          res_valid_o,
  input wire plt_pkg::res_t res_o
);
  import plt_pkg::*;

  logic cmd_valid_op;
  assign cmd_valid_op = (cmd_i.op == OP_TICK) || (cmd_i.op == OP_REG) ||
                        (cmd_i.op == OP_UNREG);

  a_res_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result outside a command");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_valid_op) |=> busy)
    else $error("command not taken");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !busy)
    else $error("busy after last transfer");

  a_fall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(res_valid_o && res_o.last))
    else $error("command ended without last transfer");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.event_res <= EV_NOTFOUND))
    else $error("illegal event code");

endmodule

bind periodic_listener_timer_table_core plt_checker u_plt_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plt_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 120;
  localparam int unsigned Phases      = 4;
  localparam logic [1:0]  OpUnused    = 2'd3;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    res_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start       = 1'b0;
  logic        busy;
  cmd_t        cmd_i       = '0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        res_valid_o;
  res_t        res_o;

  periodic_listener_timer_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // timer table mirror
  logic [31:0] interval_us;
  int          n_entries;
  logic [7:0]  tbl_key       [TableEntries];
  logic [31:0] tbl_period    [TableEntries];
  longint      tbl_remaining [TableEntries];

  res_t        step_out [MaxResults];
  int          step_n;
  res_t        expected_events [$];

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned idle_pct   = 0;

  dir_row_t directed_rows [29] = '{
    '{'{OP_TICK,  8'h00, 32'h0000_0000}, 1'b1, '{EV_NONE,     8'h00, 1'b1}},
    '{'{OP_UNREG, 8'h05, 32'h0000_0000}, 1'b1, '{EV_NOTFOUND, 8'h05, 1'b1}},
    '{'{OP_REG,   8'h00, 32'h0000_0000}, 1'b1, '{EV_ADDED,    8'h00, 1'b1}},
    '{'{OP_REG,   8'hFF, 32'hFFFF_FFFF}, 1'b1, '{EV_ADDED,    8'hFF, 1'b1}},
    '{'{OP_REG,   8'h07, 32'd1000},      1'b1, '{EV_ADDED,    8'h07, 1'b1}},
    '{'{OP_TICK,  8'hFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_REG,   8'h07, 32'd1},         1'b1, '{EV_UPDATED,  8'h07, 1'b1}},
    '{'{OpUnused, 8'hA5, 32'h5A5A_5A5A}, 1'b0, '0},
    '{'{OP_UNREG, 8'h00, 32'h0000_0000}, 1'b1, '{EV_REMOVED,  8'h00, 1'b1}},
    '{'{OP_TICK,  8'h00, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h10, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h11, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h12, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h13, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h14, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h15, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h16, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h17, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h18, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h19, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h1A, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h1B, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h1C, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'h1D, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_REG,   8'hAA, 32'd5},         1'b1, '{EV_FULL,     8'hAA, 1'b1}},
    '{'{OP_REG,   8'h07, 32'h0000_0000}, 1'b1, '{EV_UPDATED,  8'h07, 1'b1}},
    '{'{OP_TICK,  8'h00, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_UNREG, 8'h07, 32'h0000_0000}, 1'b1, '{EV_REMOVED,  8'h07, 1'b1}},
    '{'{OP_TICK,  8'h00, 32'h0000_0000}, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic res_t make_event(event_e ev, logic [7:0] id, logic last);
    res_t r;
    r.event_res = ev;
    r.fired_id  = id;
    r.last      = last;
    return r;
  endfunction

  function automatic void add_expected(res_t r);
    expected_events = {expected_events, r};
  endfunction

  function automatic int find_listener(logic [7:0] id);
    for (int i = 0; i < n_entries; i++) begin
      if (tbl_key[i] == id) return i;
    end
    return -1;
  endfunction

  // advances the mirror by one command, leaves its results in step_out
  function automatic void step_timers(cmd_t c);
    logic [7:0] fired [MaxResults];
    int         nf;
    int         pos;
    nf     = 0;
    step_n = 0;
    case (c.op)
      OP_TICK: begin
        for (int i = 0; i < n_entries; i++) begin
          tbl_remaining[i] -= longint'({32'd0, interval_us});
          if (tbl_remaining[i] <= 0) begin
            tbl_remaining[i] = longint'({32'd0, tbl_period[i]});
            if (nf < MaxResults) begin
              fired[nf] = tbl_key[i];
              nf++;
            end
          end
        end
        if (nf == 0) begin
          step_out[0] = make_event(EV_NONE, 8'h00, 1'b1);
          step_n = 1;
        end else begin
          for (int k = 0; k < nf; k++) begin
            step_out[k] = make_event(EV_FIRED, fired[k], k == nf - 1);
          end
          step_n = nf;
        end
      end
      OP_REG: begin
        pos = find_listener(c.listener_id);
        if (pos >= 0) begin
          tbl_period[pos]    = c.period_us;
          tbl_remaining[pos] = longint'({32'd0, c.period_us});
          step_out[0] = make_event(EV_UPDATED, c.listener_id, 1'b1);
        end else if (n_entries >= TableEntries) begin
          step_out[0] = make_event(EV_FULL, c.listener_id, 1'b1);
        end else begin
          tbl_key[n_entries]       = c.listener_id;
          tbl_period[n_entries]    = c.period_us;
          tbl_remaining[n_entries] = longint'({32'd0, c.period_us});
          n_entries++;
          step_out[0] = make_event(EV_ADDED, c.listener_id, 1'b1);
        end
        step_n = 1;
      end
      OP_UNREG: begin
        pos = find_listener(c.listener_id);
        if (pos < 0) begin
          step_out[0] = make_event(EV_NOTFOUND, c.listener_id, 1'b1);
        end else begin
          for (int i = pos; i < n_entries - 1; i++) begin
            tbl_key[i]       = tbl_key[i + 1];
            tbl_period[i]    = tbl_period[i + 1];
            tbl_remaining[i] = tbl_remaining[i + 1];
          end
          n_entries--;
          step_out[0] = make_event(EV_REMOVED, c.listener_id, 1'b1);
        end
        step_n = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   sel;
    sel = $urandom_range(99);
    if (sel < 35) c.op = OP_TICK;
    else if (sel < 75) c.op = OP_REG;
    else if (sel < 95) c.op = OP_UNREG;
    else c.op = OpUnused;
    if ($urandom_range(3) == 0) begin
      c.listener_id = 8'($urandom_range(255));
    end else if (c.op == OP_UNREG && n_entries > 0 && $urandom_range(1) == 1) begin
      c.listener_id = tbl_key[$urandom_range(n_entries - 1)];
    end else begin
      c.listener_id = 8'($urandom_range(23));
    end
    case ($urandom_range(7))
      0:       c.period_us = '0;
      1:       c.period_us = '1;
      2:       c.period_us = $urandom;
      default: c.period_us = $urandom_range(5000);
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string what, res_t want, res_t got);
    if (mismatches < 10) begin
      $display("%s: expected ev %0d id %0d last %0d, got ev %0d id %0d last %0d", what,
               want.event_res, want.fired_id, want.last,
               got.event_res, got.fired_id, got.last);
    end
    mismatches++;
  endtask

  // returns at the edge that takes the transfer
  task automatic issue(cmd_t c, logic typed, res_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    step_timers(c);
    if (typed) begin
      add_expected(want);
    end else begin
      for (int k = 0; k < step_n; k++) add_expected(step_out[k]);
    end
  endtask

  // wait for the table to go quiet; an ignored command leaves nothing to wait on
  task automatic settle();
    start <= 1'b0;
    while (expected_events.size() != 0 || busy) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [31:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    interval_us = value;
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    res_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end else if (rst_ni && res_valid_o) begin
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected transfer", '0, res_o);
      end else begin
        want = expected_events.pop_front();
        if (res_o.event_res !== want.event_res || res_o.fired_id !== want.fired_id ||
            res_o.last !== want.last) begin
          report_mismatch("mismatch", want, res_o);
        end
      end
    end
  end

  initial begin
    cmd_t        c;
    int unsigned sent;
    logic [31:0] phase_interval [Phases];
    int unsigned phase_idle     [Phases];
    rst_ni <= 1'b0;
    phase_interval = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'($urandom_range(200, 4000))};
    phase_idle     = '{0, 85, 0, 15};
    interval_us = 32'd1000;
    n_entries   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < Phases; ph++) begin
      write_interval(phase_interval[ph]);
      idle_pct = phase_idle[ph];
      sent = 0;
      while (sent < RandomItems / Phases) begin
        c = random_cmd();
        issue(c, 1'b0, '0);
        if (c.op != OpUnused) sent++;
      end
    end

    settle();
    if (expected_events.size() != 0) begin
      if (mismatches < 10) $display("%0d results missing", expected_events.size());
      mismatches += expected_events.size();
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
